/* src/sjsm_pkg.sv */
package sjsm_pkg;

   // default build values
   localparam int WINDOW_DEPTH_DEF   = 8;
   localparam int STEPS_PER_SLOT_DEF = 320;
   localparam int LAST_SLOT_DEF      = 7;

   // field widths
   localparam int POS_W   = 24;
   localparam int REL_W   = 25;
   localparam int LOAD_W  = 10;
   localparam int TOL_W   = 16;
   localparam int LIMIT_W = 4;
   localparam int CNT_W   = 32;
   localparam int SUM_W   = 48;
   localparam int EVENT_W = 2;
   localparam int LOWS_W  = 4;
   localparam int CSR_IW  = 2;
   localparam int CSR_DW  = 24;

   // register reset values
   localparam logic [LOAD_W-1:0]  THRESH_RST   = 10'd150;
   localparam logic [LIMIT_W-1:0] LIMIT_RST    = 4'd4;
   localparam logic [TOL_W-1:0]   TOL_RST      = 16'd200;
   localparam logic [POS_W-1:0]   FLAG_POS_RST = 24'd0;
   localparam logic [LOAD_W-1:0]  LOAD_NONE    = 10'd1023;

   // register indexes
   localparam logic [CSR_IW-1:0] CSR_THRESH   = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_LIMIT    = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_TOL      = 2'd2;
   localparam logic [CSR_IW-1:0] CSR_FLAG_POS = 2'd3;

   // operations
   localparam logic OP_NEW_MOVE = 1'b0;
   localparam logic OP_SAMPLE   = 1'b1;

   // result events
   localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
   localparam logic [EVENT_W-1:0] EV_SKIP    = 2'd1;
   localparam logic [EVENT_W-1:0] EV_JAM     = 2'd2;
   localparam logic [EVENT_W-1:0] EV_IGNORED = 2'd3;

   // window commands from the sequencer
   typedef struct packed {
      logic clear;
      logic push;
      logic start;
   } sjsm_win_cmd_type;

   // window status back to the sequencer
   typedef struct packed {
      logic full;
      logic full_on_push;
      logic done;
   } sjsm_win_stat_type;

endpackage

/* src/sjsm_window.sv */
module sjsm_window import sjsm_pkg::*; #(
   parameter int DEPTH = WINDOW_DEPTH_DEF,
   localparam int AW   = $clog2(DEPTH),
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  sjsm_win_cmd_type  cmd,
   input  logic [LOAD_W-1:0] push_load,
   input  logic [LOAD_W-1:0] threshold,
   output sjsm_win_stat_type stat,
   output logic [CW-1:0]     lows
);

   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

   logic [LOAD_W-1:0] mem [DEPTH];
   logic [LOAD_W-1:0] rd_ff;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic [CW-1:0]     lows_ff, lows_in;
   logic              scanning_ff, scanning_in;
   logic              done_ff, done_in;

   // write pointer and fill level
   always_comb begin
      idx_in  = idx_ff;
      fill_in = fill_ff;
      if (cmd.clear) begin
         idx_in  = '0;
         fill_in = '0;
      end else if (cmd.push) begin
         idx_in = (idx_ff == LAST_C) ? '0 : idx_ff + 1'b1;
         if (fill_ff != DEPTH_C) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   // scan sequencer: one entry read and one compare per cycle
   always_comb begin
      scanning_in = scanning_ff;
      scan_in     = scan_ff;
      lows_in     = lows_ff;
      done_in     = 1'b0;
      if (cmd.start) begin
         scanning_in = 1'b1;
         scan_in     = '0;
         lows_in     = '0;
      end else if (scanning_ff) begin
         if (scan_ff != '0 && rd_ff < threshold) begin
            lows_in = lows_ff + 1'b1;
         end
         if (scan_ff == DEPTH_C) begin
            scanning_in = 1'b0;
            done_in     = 1'b1;
         end else begin
            scan_in = scan_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         fill_ff     <= '0;
         scanning_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         idx_ff      <= idx_in;
         fill_ff     <= fill_in;
         scanning_ff <= scanning_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      lows_ff <= lows_in;
   end

   // window storage, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.push && !cmd.clear) begin
         mem[idx_ff] <= push_load;
      end
   end

   always_ff @(posedge clock) begin
      if (scanning_ff && scan_ff != DEPTH_C) begin
         rd_ff <= mem[scan_ff[AW-1:0]];
      end
   end

   assign stat.full         = (fill_ff == DEPTH_C);
   assign stat.full_on_push = (fill_ff >= CW'(DEPTH - 1));
   assign stat.done         = done_ff;
   assign lows              = lows_ff;

endmodule

/* src/stepper_jam_and_skip_monitor_core.sv */
// channel  | ports                         | handshake
// ---------+-------------------------------+-----------------------------
// request  | req_valid, req_stall, req_*   | beat when valid and !stall
// response | rsp_valid, rsp_stall, rsp_*   | beat when valid and !stall
// csr      | csr_we, csr_index, csr_wdata  | write when csr_we, no wait
//
// a new-move beat or a sample without a full window passes ST_REL and ST_DECIDE
// on to ST_OUT; a cruise sample that leaves the window full also passes ST_SCAN
// for the serial walk over the window memory through the one shared
// comparator.
// one beat is in flight at a time: req_stall is high from acceptance until
// the response beat is taken, so rsp_stall holds the whole block.
// reset is synchronous and active high; it restores register defaults and
// clears statistics, totals and the abort latch; req_stall is high during it.
module stepper_jam_and_skip_monitor_core import sjsm_pkg::*; #(
   parameter int WINDOW_DEPTH   = WINDOW_DEPTH_DEF,
   parameter int STEPS_PER_SLOT = STEPS_PER_SLOT_DEF,
   parameter int LAST_SLOT      = LAST_SLOT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_operation,
   input  logic signed [POS_W-1:0]   req_position,
   input  logic                      req_on_flag,
   input  logic [LOAD_W-1:0]         req_load_reading,
   input  logic                      req_at_cruise,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [EVENT_W-1:0]        rsp_event_res,
   output logic signed [REL_W-1:0]   rsp_relative_position,
   output logic [LOWS_W-1:0]         rsp_low_count,
   output logic [CNT_W-1:0]          rsp_sample_count,
   output logic [SUM_W-1:0]          rsp_load_sum,
   output logic [LOAD_W-1:0]         rsp_load_min,
   output logic [CNT_W-1:0]          rsp_jam_total,
   output logic [CNT_W-1:0]          rsp_skip_total,
   input  logic                      csr_we,
   input  logic [CSR_IW-1:0]         csr_index,
   input  logic [CSR_DW-1:0]         csr_wdata
);

   localparam int CW      = $clog2(WINDOW_DEPTH + 1);
   localparam int LW      = (CW > LOWS_W) ? CW : LOWS_W;
   localparam int CMP_W   = REL_W + 2;
   localparam int FAR_SPAN = LAST_SLOT * STEPS_PER_SLOT;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REL    = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   logic [2:0]               state_ff, state_in;

   // captured request beat
   logic                     op_ff;
   logic signed [POS_W-1:0]  pos_ff;
   logic                     flag_ff;
   logic [LOAD_W-1:0]        load_ff;
   logic                     cruise_ff;

   // configuration
   logic [LOAD_W-1:0]        thresh_ff;
   logic [LIMIT_W-1:0]       limit_ff;
   logic [TOL_W-1:0]         tol_ff;
   logic signed [POS_W-1:0]  flag_pos_ff;

   // working and result registers
   logic signed [REL_W-1:0]  rel_ff, rel_in;
   logic signed [CMP_W-1:0]  far_ff, far_in;
   logic [EVENT_W-1:0]       event_ff, event_in;
   logic [LOWS_W-1:0]        low_ff, low_in;
   logic [CNT_W-1:0]         samples_ff, samples_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [LOAD_W-1:0]        min_ff, min_in;
   logic [CNT_W-1:0]         jams_ff, jams_in;
   logic [CNT_W-1:0]         skips_ff, skips_in;
   logic                     aborted_ff, aborted_in;

   sjsm_win_cmd_type         win_cmd;
   sjsm_win_stat_type        win_stat;
   logic [CW-1:0]            win_lows;

   logic signed [CMP_W-1:0]  rel_x;
   logic signed [CMP_W-1:0]  tol_x;
   logic                     skip_hit;
   logic [SUM_W:0]           sum_wide;
   logic [LW-1:0]            lows_ext;

   // skip zone test and saturating sum
   assign rel_x    = CMP_W'(rel_ff);
   assign tol_x    = signed'(CMP_W'(tol_ff));
   assign skip_hit = flag_ff && (rel_x > tol_x) && (rel_x < far_ff);
   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(load_ff);
   assign lows_ext = LW'(win_lows);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      rel_in     = rel_ff;
      far_in     = far_ff;
      event_in   = event_ff;
      low_in     = low_ff;
      samples_in = samples_ff;
      sum_in     = sum_ff;
      min_in     = min_ff;
      jams_in    = jams_ff;
      skips_in   = skips_ff;
      aborted_in = aborted_ff;
      win_cmd    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_REL;
            end
         end
         ST_REL: begin
            rel_in   = REL_W'(pos_ff) - REL_W'(flag_pos_ff);
            far_in   = signed'(CMP_W'(FAR_SPAN)) - signed'(CMP_W'(tol_ff));
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            event_in = EV_NONE;
            low_in   = '0;
            state_in = ST_OUT;
            if (op_ff == OP_NEW_MOVE) begin
               rel_in        = '0;
               samples_in    = '0;
               sum_in        = '0;
               min_in        = LOAD_NONE;
               aborted_in    = 1'b0;
               win_cmd.clear = 1'b1;
            end else if (aborted_ff) begin
               event_in = EV_IGNORED;
            end else if (skip_hit) begin
               event_in   = EV_SKIP;
               aborted_in = 1'b1;
               if (skips_ff != '1) begin
                  skips_in = skips_ff + 1'b1;
               end
            end else if (load_ff != '0) begin
               if (samples_ff != '1) begin
                  samples_in = samples_ff + 1'b1;
               end
               sum_in = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
               if (load_ff < min_ff) begin
                  min_in = load_ff;
               end
               if (!cruise_ff) begin
                  win_cmd.clear = 1'b1;
               end else begin
                  win_cmd.push = 1'b1;
                  if (win_stat.full_on_push) begin
                     win_cmd.start = 1'b1;
                     state_in      = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (win_stat.done) begin
               low_in   = (lows_ext > LW'(15)) ? 4'd15 : lows_ext[LOWS_W-1:0];
               state_in = ST_OUT;
               if (lows_ext >= LW'(limit_ff)) begin
                  event_in   = EV_JAM;
                  aborted_in = 1'b1;
                  if (jams_ff != '1) begin
                     jams_in = jams_ff + 1'b1;
                  end
               end
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         samples_ff <= '0;
         sum_ff     <= '0;
         min_ff     <= LOAD_NONE;
         jams_ff    <= '0;
         skips_ff   <= '0;
         aborted_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         samples_ff <= samples_in;
         sum_ff     <= sum_in;
         min_ff     <= min_in;
         jams_ff    <= jams_in;
         skips_ff   <= skips_in;
         aborted_ff <= aborted_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      rel_ff   <= rel_in;
      far_ff   <= far_in;
      event_ff <= event_in;
      low_ff   <= low_in;
   end

   // capture the request beat
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         op_ff     <= req_operation;
         pos_ff    <= req_position;
         flag_ff   <= req_on_flag;
         load_ff   <= req_load_reading;
         cruise_ff <= req_at_cruise;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff   <= THRESH_RST;
         limit_ff    <= LIMIT_RST;
         tol_ff      <= TOL_RST;
         flag_pos_ff <= FLAG_POS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESH:   thresh_ff   <= csr_wdata[LOAD_W-1:0];
            CSR_LIMIT:    limit_ff    <= csr_wdata[LIMIT_W-1:0];
            CSR_TOL:      tol_ff      <= csr_wdata[TOL_W-1:0];
            CSR_FLAG_POS: flag_pos_ff <= signed'(csr_wdata[POS_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   // load window with serial deep-low count
   sjsm_window #(
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .cmd       (win_cmd),
      .push_load (load_ff),
      .threshold (thresh_ff),
      .stat      (win_stat),
      .lows      (win_lows)
   );

   // ports
   assign req_stall             = reset || (state_ff != ST_IDLE);
   assign rsp_valid             = (state_ff == ST_OUT);
   assign rsp_event_res         = event_ff;
   assign rsp_relative_position = rel_ff;
   assign rsp_low_count         = low_ff;
   assign rsp_sample_count      = samples_ff;
   assign rsp_load_sum          = sum_ff;
   assign rsp_load_min          = min_ff;
   assign rsp_jam_total         = jams_ff;
   assign rsp_skip_total        = skips_ff;

`ifndef ASSERT_OFF
   // a jam is only reported over a full window
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == EV_JAM) |-> win_stat.full)
      else $error("jam reported without a full window");

   // nonzero low count needs a full window
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_low_count != '0) |-> win_stat.full)
      else $error("low count reported without a full window");

   // ignored samples only while the abort latch is set
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == EV_IGNORED) |-> aborted_ff)
      else $error("sample ignored without abort");

   // an accepted beat always starts the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_REL))
      else $error("accepted beat did not start processing");
`endif

endmodule

/* verif/stepper_jam_and_skip_monitor_core_tb.sv */
module stepper_jam_and_skip_monitor_core_tb import sjsm_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // one request beat
   typedef struct packed {
      logic                    op;
      logic signed [POS_W-1:0] position;
      logic                    on_flag;
      logic [LOAD_W-1:0]       load;
      logic                    cruise;
   } req_type;

   // one response beat
   typedef struct packed {
      logic [EVENT_W-1:0]      ev;
      logic signed [REL_W-1:0] rel;
      logic [LOWS_W-1:0]       lows;
      logic [CNT_W-1:0]        samples;
      logic [SUM_W-1:0]        load_sum;
      logic [LOAD_W-1:0]       load_min;
      logic [CNT_W-1:0]        jams;
      logic [CNT_W-1:0]        skips;
   } rsp_type;

   // directed row: request, then an optional hand-written event, offset and low count
   typedef struct packed {
      logic                    op;
      logic signed [POS_W-1:0] position;
      logic                    on_flag;
      logic [LOAD_W-1:0]       load;
      logic                    cruise;
      logic                    typed;
      logic [EVENT_W-1:0]      ev;
      logic signed [REL_W-1:0] rel;
      logic [LOWS_W-1:0]       lows;
   } dir_row_type;

   localparam int DIR_ROWS    = 26;
   localparam int PHASES      = 6;
   localparam int PHASE_BEATS = 100;

   // directed sequence, checked against default register values
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{OP_NEW_MOVE,  24'sd0,       1'b0, 10'd0,    1'b0, 1'b1, EV_NONE,    25'sd0,       4'd0},
      '{OP_SAMPLE,    24'sd0,       1'b1, 10'd0,    1'b0, 1'b1, EV_NONE,    25'sd0,       4'd0},
      '{OP_SAMPLE,    24'sd8388607, 1'b1, 10'd1023, 1'b0, 1'b1, EV_NONE,    25'sd8388607, 4'd0},
      '{OP_SAMPLE,   -24'sd8388608, 1'b0, 10'd1,    1'b1, 1'b1, EV_NONE,   -25'sd8388608, 4'd0},
      '{OP_SAMPLE,    24'sd1000,    1'b0, 10'd500,  1'b1, 1'b0, EV_NONE,    25'sd0,       4'd0},
      '{OP_SAMPLE,    24'sd1000,    1'b0, 10'd500,  1'b1, 1'b0, EV_NONE,    25'sd0,       4'd0},
      '{OP_SAMPLE,    24'sd1000,    1'b0, 10'd500,  1'b1, 1'b0, EV_NONE,    25'sd0,       4'd0},
      '{OP_SAMPLE,    24'sd1000,    1'b0, 10'd500,  1'b1, 1'b0, EV_NONE,    25'sd0,       4'd0},
      '{OP_SAMPLE,    24'sd1000,    1'b0, 10'd500,  1'b1, 1'b0, EV_NONE,    25'sd0,       4'd0},
      '{OP_SAMPLE,    24'sd1000,    1'b0, 10'd500,  1'b1, 1'b0, EV_NONE,    25'sd0,       4'd0},
      '{OP_SAMPLE,    24'sd1000,    1'b0, 10'd149,  1'b1, 1'b1, EV_NONE,    25'sd1000,    4'd2},
      '{OP_SAMPLE,    24'sd1000,    1'b0, 10'd150,  1'b1, 1'b1, EV_NONE,    25'sd1000,    4'd1},
      '{OP_SAMPLE,    24'sd1000,    1'b0, 10'd300,  1'b0, 1'b1, EV_NONE,    25'sd1000,    4'd0},
      '{OP_SAMPLE,    24'sd200,     1'b1, 10'd50,   1'b0, 1'b1, EV_NONE,    25'sd200,     4'd0},
      '{OP_SAMPLE,    24'sd2040,    1'b1, 10'd50,   1'b0, 1'b1, EV_NONE,    25'sd2040,    4'd0},
      '{OP_SAMPLE,    24'sd201,     1'b1, 10'd50,   1'b0, 1'b1, EV_SKIP,    25'sd201,     4'd0},
      '{OP_SAMPLE,   -24'sd5,       1'b1, 10'd60,   1'b1, 1'b1, EV_IGNORED, -25'sd5,      4'd0},
      '{OP_NEW_MOVE,  24'sd77,      1'b1, 10'd9,    1'b1, 1'b1, EV_NONE,    25'sd0,       4'd0},
      '{OP_SAMPLE,   -24'sd100,     1'b1, 10'd1,    1'b1, 1'b0, EV_NONE,    25'sd0,       4'd0},
      '{OP_SAMPLE,   -24'sd100,     1'b1, 10'd1,    1'b1, 1'b0, EV_NONE,    25'sd0,       4'd0},
      '{OP_SAMPLE,   -24'sd100,     1'b1, 10'd1,    1'b1, 1'b0, EV_NONE,    25'sd0,       4'd0},
      '{OP_SAMPLE,   -24'sd100,     1'b1, 10'd1,    1'b1, 1'b0, EV_NONE,    25'sd0,       4'd0},
      '{OP_SAMPLE,   -24'sd100,     1'b1, 10'd1,    1'b1, 1'b0, EV_NONE,    25'sd0,       4'd0},
      '{OP_SAMPLE,   -24'sd100,     1'b1, 10'd1,    1'b1, 1'b0, EV_NONE,    25'sd0,       4'd0},
      '{OP_SAMPLE,   -24'sd100,     1'b1, 10'd1,    1'b1, 1'b0, EV_NONE,    25'sd0,       4'd0},
      '{OP_SAMPLE,    24'sd2041,    1'b1, 10'd149,  1'b1, 1'b1, EV_JAM,     25'sd2041,    4'd8}
   };

   // dut ports
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_operation = OP_NEW_MOVE;
   logic signed [POS_W-1:0] req_position = '0;
   logic                    req_on_flag = 1'b0;
   logic [LOAD_W-1:0]       req_load_reading = '0;
   logic                    req_at_cruise = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [EVENT_W-1:0]      rsp_event_res;
   logic signed [REL_W-1:0] rsp_relative_position;
   logic [LOWS_W-1:0]       rsp_low_count;
   logic [CNT_W-1:0]        rsp_sample_count;
   logic [SUM_W-1:0]        rsp_load_sum;
   logic [LOAD_W-1:0]       rsp_load_min;
   logic [CNT_W-1:0]        rsp_jam_total;
   logic [CNT_W-1:0]        rsp_skip_total;
   logic                    csr_we = 1'b0;
   logic [CSR_IW-1:0]       csr_index = CSR_THRESH;
   logic [CSR_DW-1:0]       csr_wdata = '0;

   // monitor model: registers
   logic [LOAD_W-1:0]       thresh_q;
   logic [LIMIT_W-1:0]      limit_q;
   logic [TOL_W-1:0]        tol_q;
   logic signed [POS_W-1:0] flag_pos_q;

   // monitor model: per-move and lifetime state
   logic [LOAD_W-1:0]       win_loads [WINDOW_DEPTH_DEF];
   int                      win_ptr;
   int                      win_fill;
   logic [CNT_W-1:0]        n_samples;
   logic [SUM_W-1:0]        loads_total;
   logic [LOAD_W-1:0]       lightest;
   logic [CNT_W-1:0]        jam_cnt;
   logic [CNT_W-1:0]        skip_cnt;
   logic                    move_aborted;

   // bookkeeping
   rsp_type expected_rsp_q [$];
   int   mismatch_count = 0;
   int   beats_sent = 0;
   int   rsp_seen = 0;
   int   ev_seen [4] = '{0, 0, 0, 0};
   int   burst_left = 0;
   int   stall_mode = 0;
   int   stall_run = 0;

   stepper_jam_and_skip_monitor_core u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_position          (req_position),
      .req_on_flag           (req_on_flag),
      .req_load_reading      (req_load_reading),
      .req_at_cruise         (req_at_cruise),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_event_res         (rsp_event_res),
      .rsp_relative_position (rsp_relative_position),
      .rsp_low_count         (rsp_low_count),
      .rsp_sample_count      (rsp_sample_count),
      .rsp_load_sum          (rsp_load_sum),
      .rsp_load_min          (rsp_load_min),
      .rsp_jam_total         (rsp_jam_total),
      .rsp_skip_total        (rsp_skip_total),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #5 clock = ~clock;

   // drop per-move statistics and the window, release the abort latch
   function automatic void clear_move();
      foreach (win_loads[k]) win_loads[k] = '0;
      win_ptr      = 0;
      win_fill     = 0;
      n_samples    = '0;
      loads_total  = '0;
      lightest     = LOAD_NONE;
      move_aborted = 1'b0;
   endfunction

   // advance the monitor model by one request and return the response it gives
   function automatic rsp_type monitor_step(req_type it);
      rsp_type          r;
      longint           pos_l;
      longint           fpos_l;
      longint           rel_l;
      longint           tol_l;
      longint           far_l;
      logic [SUM_W:0]   wide_sum;
      int               lows;
      r = '0;
      if (it.op == OP_NEW_MOVE) begin
         clear_move();
      end else begin
         pos_l  = $signed(it.position);
         fpos_l = flag_pos_q;
         rel_l  = pos_l - fpos_l;
         r.rel  = rel_l[REL_W-1:0];
         tol_l  = tol_q;
         far_l  = longint'(LAST_SLOT_DEF * STEPS_PER_SLOT_DEF) - tol_l;
         if (move_aborted) begin
            r.ev = EV_IGNORED;
         end else if (it.on_flag && rel_l > tol_l && rel_l < far_l) begin
            // flag seen well outside its zone: steps were lost
            if (skip_cnt != '1) skip_cnt++;
            move_aborted = 1'b1;
            r.ev = EV_SKIP;
         end else if (it.load != '0) begin
            if (n_samples != '1) n_samples++;
            wide_sum = loads_total + it.load;
            loads_total = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
            if (it.load < lightest) lightest = it.load;
            // window only fills at cruise, anything else empties it
            if (!it.cruise) begin
               foreach (win_loads[k]) win_loads[k] = '0;
               win_ptr  = 0;
               win_fill = 0;
            end else begin
               win_loads[win_ptr] = it.load;
               win_ptr = (win_ptr + 1) % WINDOW_DEPTH_DEF;
               if (win_fill < WINDOW_DEPTH_DEF) win_fill++;
            end
            if (win_fill == WINDOW_DEPTH_DEF) begin
               lows = 0;
               foreach (win_loads[k]) if (win_loads[k] < thresh_q) lows++;
               r.lows = (lows > 15) ? 4'd15 : LOWS_W'(lows);
               if (lows >= limit_q) begin
                  if (jam_cnt != '1) jam_cnt++;
                  move_aborted = 1'b1;
                  r.ev = EV_JAM;
               end
            end
         end
      end
      r.samples  = n_samples;
      r.load_sum = loads_total;
      r.load_min = lightest;
      r.jams     = jam_cnt;
      r.skips    = skip_cnt;
      return r;
   endfunction

   // random request, shaped to build full windows near the low threshold
   function automatic req_type random_item();
      req_type it;
      int   pick;
      int   t;
      it = '0;
      pick = $urandom_range(0, 99);
      it.op = (pick < 4 || (move_aborted && pick < 40)) ? OP_NEW_MOVE : OP_SAMPLE;
      if ($urandom_range(0, 6) == 0)
         it.position = POS_W'($urandom);
      else
         it.position = POS_W'(int'(flag_pos_q) + int'($urandom_range(0, 3000)) - 500);
      it.on_flag = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         it.load = '0;
      end else if (pick < 5) begin
         it.load = LOAD_W'($urandom_range(1, 1023));
      end else begin
         t = int'(thresh_q) + int'($urandom_range(0, 80)) - 40;
         if (t < 1) t = 1;
         if (t > 1023) t = 1023;
         it.load = t[LOAD_W-1:0];
      end
      it.cruise = ($urandom_range(0, 9) != 0);
      return it;
   endfunction

   function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         if (mismatch_count < 10)
            $display("%s mismatch in response %0d: expected %0h, got %0h",
                     what, rsp_seen, want, got);
         mismatch_count++;
      end
   endfunction

   // register write, mirrored into the model
   task automatic csr_write(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_THRESH:   thresh_q   = data[LOAD_W-1:0];
         CSR_LIMIT:    limit_q    = data[LIMIT_W-1:0];
         CSR_TOL:      tol_q      = data[TOL_W-1:0];
         CSR_FLAG_POS: flag_pos_q = data[POS_W-1:0];
         default: ;
      endcase
   endtask

   // all four registers, unused upper bits filled with noise
   task automatic set_regs(logic [LOAD_W-1:0] thr, logic [LIMIT_W-1:0] lim,
                           logic [TOL_W-1:0] tol, logic signed [POS_W-1:0] fpos);
      csr_write(CSR_THRESH,   {(CSR_DW-LOAD_W)'($urandom), thr});
      csr_write(CSR_LIMIT,    {(CSR_DW-LIMIT_W)'($urandom), lim});
      csr_write(CSR_TOL,      {(CSR_DW-TOL_W)'($urandom), tol});
      csr_write(CSR_FLAG_POS, fpos);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // present one beat, hold it until taken, then log what should come back
   task automatic drive_beat(req_type it, logic typed, logic [EVENT_W-1:0] ev,
                             logic signed [REL_W-1:0] rel, logic [LOWS_W-1:0] lows);
      rsp_type want;
      req_valid        <= 1'b1;
      req_operation    <= it.op;
      req_position     <= it.position;
      req_on_flag      <= it.on_flag;
      req_load_reading <= it.load;
      req_at_cruise    <= it.cruise;
      do @(posedge clock); while (req_stall);
      want = monitor_step(it);
      if (typed) begin
         want.ev   = ev;
         want.rel  = rel;
         want.lows = lows;
      end
      expected_rsp_q.push_back(want);
      beats_sent++;
   endtask

   // sender bursts: keep valid up inside a burst, drop it and idle between bursts
   task automatic pace_sender();
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         if ($urandom_range(0, 24) == 0)
            wait_drained();
         else
            repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 15);
      end
   endtask

   // receiver stall pattern: free, light, heavy or periodic, switched now and then
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_run  <= $urandom_range(20, 200);
      end else begin
         stall_run <= stall_run - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_run[2];
      endcase
   end

   // response checker
   always @(posedge clock) begin : rsp_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_event_res, rsp_relative_position, rsp_low_count, rsp_sample_count,
                 rsp_load_sum, rsp_load_min, rsp_jam_total, rsp_skip_total};
         if (expected_rsp_q.size() == 0) begin
            if (mismatch_count < 10)
               $display("response %0d arrived with nothing outstanding", rsp_seen);
            mismatch_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("event_res",         want.ev,       got.ev);
            check_field("relative_position", want.rel,      got.rel);
            check_field("low_count",         want.lows,     got.lows);
            check_field("sample_count",      want.samples,  got.samples);
            check_field("load_sum",          want.load_sum, got.load_sum);
            check_field("load_min",          want.load_min, got.load_min);
            check_field("jam_total",         want.jams,     got.jams);
            check_field("skip_total",        want.skips,    got.skips);
            ev_seen[got.ev]++;
         end
         rsp_seen++;
      end
   end

   // stimulus
   initial begin
      req_type it;
      thresh_q   = THRESH_RST;
      limit_q    = LIMIT_RST;
      tol_q      = TOL_RST;
      flag_pos_q = FLAG_POS_RST;
      jam_cnt    = '0;
      skip_cnt   = '0;
      clear_move();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed walk with reset register values
      foreach (dir_rows[i]) begin
         it = '{dir_rows[i].op, dir_rows[i].position, dir_rows[i].on_flag,
                dir_rows[i].load, dir_rows[i].cruise};
         drive_beat(it, dir_rows[i].typed, dir_rows[i].ev, dir_rows[i].rel,
                    dir_rows[i].lows);
         pace_sender();
      end

      // random phases, each under its own register setting
      for (int phase = 0; phase < PHASES; phase++) begin
         req_valid <= 1'b0;
         wait_drained();
         case (phase)
            0: set_regs(10'd0, 4'd1, 16'd0, -24'sd8388608);
            1: set_regs(10'd1023, 4'd8, 16'd65535, 24'sd8388607);
            2: set_regs(10'd200, 4'd0, 16'd100, POS_W'($urandom));
            3: set_regs(LOAD_W'($urandom), 4'd15, 16'd0, 24'sd0);
            4: set_regs(10'd300, 4'd3, 16'd50, POS_W'($urandom_range(0, 20000)));
            default: set_regs(LOAD_W'($urandom), LIMIT_W'($urandom_range(1, 8)),
                              TOL_W'($urandom_range(0, 1200)), POS_W'($urandom));
         endcase
         for (int n = 0; n < PHASE_BEATS; n++) begin
            drive_beat(random_item(), 1'b0, EV_NONE, '0, '0);
            pace_sender();
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d beats under %0d register settings", beats_sent, PHASES + 1);
      $display("responses: %0d skips, %0d jams, %0d ignored after abort",
               ev_seen[EV_SKIP], ev_seen[EV_JAM], ev_seen[EV_IGNORED]);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("timeout with %0d responses outstanding", expected_rsp_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* sim.f */
src/sjsm_pkg.sv
src/sjsm_window.sv
src/stepper_jam_and_skip_monitor_core.sv
verif/stepper_jam_and_skip_monitor_core_tb.sv
